// ===== hw/rtl/dlsq_pkg.sv =====
// ----------------------------------------------------------------------------
// dlsq_pkg
// Shared types and constants for the dual limit switch qualifier.
// ----------------------------------------------------------------------------
package dlsq_pkg;

    localparam int VOLTAGE_BITS_DEF = 10;
    localparam int COUNT_BITS_DEF   = 16;

    localparam int MINV_BITS = 10;
    localparam int TICK_BITS = 16;
    localparam int CFG_BITS  = 16;
    localparam int ADDR_BITS = 2;

    localparam logic [MINV_BITS-1:0] MIN_VOLTAGE_RST = 10'd150;
    localparam logic [TICK_BITS-1:0] HOLDOFF_RST     = 16'd300;
    localparam logic [TICK_BITS-1:0] WINDOW_RST      = 16'd100;

    localparam logic signed [7:0] VOTE_MAX = 8'sd126;
    localparam logic signed [7:0] VOTE_MIN = -8'sd126;

    typedef logic signed [7:0] vote_t;

    typedef enum logic [ADDR_BITS-1:0] {
        REG_MIN_VOLTAGE = 2'd0,
        REG_HOLDOFF     = 2'd1,
        REG_WINDOW      = 2'd2
    } cfg_reg_t;

    typedef enum logic [2:0] {
        POS_UNDEFINED = 3'd0,
        POS_CLOSE     = 3'd1,
        POS_OPEN      = 3'd2,
        POS_WORK      = 3'd3,
        POS_FAULT     = 3'd4
    } pos_t;

    function automatic vote_t vote_move(input vote_t v, input logic level);
        vote_t r;
        r = v;
        if (level) begin
            if (v < VOTE_MAX) r = v + 8'sd1;
        end else begin
            if (v > VOTE_MIN) r = v - 8'sd1;
        end
        return r;
    endfunction

    function automatic pos_t decide(input vote_t a, input vote_t b);
        pos_t r;
        priority if (a > 0 && b <= 0) r = POS_CLOSE;
        else if (a <= 0 && b > 0)     r = POS_OPEN;
        else if (a <= 0 && b <= 0)    r = POS_WORK;
        else                          r = POS_FAULT;
        return r;
    endfunction

endpackage

// ===== hw/rtl/dual_limit_switch_qualifier.sv =====
// ----------------------------------------------------------------------------
// dual_limit_switch_qualifier
// Majority-vote debouncer for two limit switches, gated by a supply check.
// ----------------------------------------------------------------------------
//  channel  | dir | handshake          | payload
//  s_       | in  | s_tvalid/s_tready  | switch levels, supply sample
//  m_       | out | m_tvalid/m_tready  | position, ready, decided
//  cfg_     | in  | cfg_wr_en          | register index, write data
//
// One item per cycle while s_tready is high; each result is registered.
// The state update for a tick is a single pass of counter and vote logic.
// A two-entry output stage (result register plus skid register) keeps
// s_tready high while one result waits; it drops only when both are full.
// aresetn is synchronous, active low, and loads the register reset values.
// ----------------------------------------------------------------------------
module dual_limit_switch_qualifier #(
    parameter int VOLTAGE_BITS = dlsq_pkg::VOLTAGE_BITS_DEF,
    parameter int COUNT_BITS   = dlsq_pkg::COUNT_BITS_DEF,
    parameter int S_DATA_BITS  = ((VOLTAGE_BITS + 2 + 7) / 8) * 8
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] switch_a_level, [1] switch_b_level, [VOLTAGE_BITS+1:2] supply_sample
    input  logic [S_DATA_BITS-1:0]            s_tdata,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [2:0] position_state, [3] ready_res, [4] decided
    output logic [7:0]                        m_tdata,

    input  logic                              cfg_wr_en,
    input  logic [dlsq_pkg::ADDR_BITS-1:0]    cfg_addr,
    input  logic [dlsq_pkg::CFG_BITS-1:0]     cfg_wr_data
);
    import dlsq_pkg::*;

    localparam int CMP_BITS = (VOLTAGE_BITS > MINV_BITS) ? VOLTAGE_BITS : MINV_BITS;

    typedef logic [COUNT_BITS-1:0] cnt_t;

    logic [MINV_BITS-1:0] min_voltage_reg;
    logic [TICK_BITS-1:0] holdoff_ticks_reg;
    logic [TICK_BITS-1:0] window_ticks_reg;

    vote_t vote_a_reg, vote_a_next;
    vote_t vote_b_reg, vote_b_next;
    cnt_t  window_left_reg, window_left_next;
    cnt_t  holdoff_left_reg, holdoff_left_next;
    logic  supply_bad_reg, supply_bad_next;
    pos_t  state_reg, state_next;
    logic  ready_reg, ready_next;
    logic  decided;

    logic                    sw_a;
    logic                    sw_b;
    logic [VOLTAGE_BITS-1:0] supply;
    logic                    supply_low;
    logic                    s_acc;
    vote_t                   va_mv, vb_mv;
    logic [7:0]              result;

    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic       skid_valid_reg;
    logic [7:0] skid_data_reg;

    assign sw_a   = s_tdata[0];
    assign sw_b   = s_tdata[1];
    assign supply = s_tdata[VOLTAGE_BITS+1:2];
    assign supply_low = CMP_BITS'(supply) < CMP_BITS'(min_voltage_reg);

    assign s_tready = !skid_valid_reg;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_voltage_reg   <= MIN_VOLTAGE_RST;
            holdoff_ticks_reg <= HOLDOFF_RST;
            window_ticks_reg  <= WINDOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_MIN_VOLTAGE: min_voltage_reg   <= cfg_wr_data[MINV_BITS-1:0];
                REG_HOLDOFF:     holdoff_ticks_reg <= cfg_wr_data[TICK_BITS-1:0];
                REG_WINDOW:      window_ticks_reg  <= cfg_wr_data[TICK_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        vote_a_next       = vote_a_reg;
        vote_b_next       = vote_b_reg;
        window_left_next  = window_left_reg;
        holdoff_left_next = holdoff_left_reg;
        supply_bad_next   = supply_bad_reg;
        state_next        = state_reg;
        ready_next        = ready_reg;
        decided           = 1'b0;
        va_mv             = vote_move(vote_a_reg, sw_a);
        vb_mv             = vote_move(vote_b_reg, sw_b);
        priority if (supply_low) begin
            supply_bad_next   = 1'b1;
            holdoff_left_next = cnt_t'(holdoff_ticks_reg);
            state_next        = POS_UNDEFINED;
            vote_a_next       = '0;
            vote_b_next       = '0;
            window_left_next  = cnt_t'(window_ticks_reg);
        end else if (supply_bad_reg) begin
            if (holdoff_left_reg == '0) supply_bad_next = 1'b0;
            holdoff_left_next = holdoff_left_reg - cnt_t'(1);
        end else if (window_left_reg != '0) begin
            vote_a_next      = va_mv;
            vote_b_next      = vb_mv;
            window_left_next = window_left_reg - cnt_t'(1);
        end else begin
            state_next       = decide(va_mv, vb_mv);
            vote_a_next      = '0;
            vote_b_next      = '0;
            window_left_next = cnt_t'(window_ticks_reg);
            ready_next       = 1'b1;
            decided          = 1'b1;
        end
        result = {3'b000, decided, ready_next, state_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vote_a_reg       <= '0;
            vote_b_reg       <= '0;
            window_left_reg  <= cnt_t'(WINDOW_RST);
            holdoff_left_reg <= cnt_t'(HOLDOFF_RST);
            supply_bad_reg   <= 1'b1;
            state_reg        <= POS_UNDEFINED;
            ready_reg        <= 1'b0;
        end else if (s_acc) begin
            vote_a_reg       <= vote_a_next;
            vote_b_reg       <= vote_b_next;
            window_left_reg  <= window_left_next;
            holdoff_left_reg <= holdoff_left_next;
            supply_bad_reg   <= supply_bad_next;
            state_reg        <= state_next;
            ready_reg        <= ready_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (s_acc || skid_valid_reg) m_valid_reg <= 1'b1;
            else if (m_tready)          m_valid_reg <= 1'b0;
            if (s_acc && m_valid_reg && !m_tready) skid_valid_reg <= 1'b1;
            else if (m_tready)                     skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_valid_reg && m_tready && skid_valid_reg) m_data_reg <= skid_data_reg;
        if (s_acc) begin
            if (m_valid_reg && !m_tready) skid_data_reg <= result;
            else                          m_data_reg    <= result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry without a result in front");

    a_decided_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[4]) |-> m_data_reg[3])
        else $error("window end without ready flag");

    a_decided_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg[4]) |-> (m_data_reg[2:0] != POS_UNDEFINED))
        else $error("window end with undefined position");

    a_vote_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (vote_a_reg <= VOTE_MAX) && (vote_a_reg >= VOTE_MIN) &&
        (vote_b_reg <= VOTE_MAX) && (vote_b_reg >= VOTE_MIN))
        else $error("vote counter out of range");

    a_low_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && supply_low) |=> (supply_bad_reg && vote_a_reg == 0 && vote_b_reg == 0))
        else $error("low supply did not clear votes");
`endif

endmodule

// ===== bench/dual_limit_switch_qualifier_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_limit_switch_qualifier_tb
// Drives switch-level and supply ticks into the qualifier under random
// stalls on both channels and compares every position result with a local
// model of the hold-off, vote and window logic or with planned values. A short
// directed plan runs first, then random phases over several register settings.
// ----------------------------------------------------------------------------
module dual_limit_switch_qualifier_tb;
    import dlsq_pkg::*;

    localparam int IDLE_PCT        = 14;
    localparam int LIMIT_CYCLES    = 200000;
    localparam int PRESSURE_AT     = 100;
    localparam int PRESSURE_CYCLES = 400;
    localparam int MAX_REPORTS     = 10;
    localparam int NUM_PHASES      = 8;

    localparam logic [ADDR_BITS-1:0] REG_SPARE = 2'd3;

    typedef enum logic {ROW_TICK, ROW_CFG} row_kind_t;

    typedef struct packed {
        pos_t pos;
        logic ready;
        logic decided;
    } qual_res_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [ADDR_BITS-1:0] idx;
        logic [CFG_BITS-1:0]  val;
        logic                 a;
        logic                 b;
        logic [9:0]           supply;
        logic                 known;
        qual_res_t            res;
    } plan_row_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_wr_en;
    logic [ADDR_BITS-1:0] cfg_addr;
    logic [CFG_BITS-1:0]  cfg_wr_data;

    // local copy of registers and qualifier state
    logic [9:0]  cfg_minv;
    logic [15:0] cfg_hold;
    logic [15:0] cfg_win;
    vote_t       vote_a;
    vote_t       vote_b;
    logic [15:0] win_left;
    logic [15:0] hold_left;
    logic        supply_low;
    pos_t        position;
    logic        ready_seen;

    qual_res_t   pending_res[$];
    plan_row_t   plan[$];
    int          errors;
    int          results_seen;
    bit          calm;

    dual_limit_switch_qualifier uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
    end

    function automatic vote_t step_vote(vote_t v, logic level);
        vote_t r;
        r = v;
        if (level) begin
            if (v < VOTE_MAX) r = v + 8'sd1;
        end else begin
            if (v > VOTE_MIN) r = v - 8'sd1;
        end
        return r;
    endfunction

    function automatic qual_res_t qualify_tick(logic a, logic b, logic [9:0] v);
        qual_res_t r;
        r.decided = 1'b0;
        if (v < cfg_minv) begin
            supply_low = 1'b1;
            hold_left  = cfg_hold;
            position   = POS_UNDEFINED;
            vote_a     = 8'sd0;
            vote_b     = 8'sd0;
            win_left   = cfg_win;
        end else if (supply_low) begin
            if (hold_left == 16'd0) supply_low = 1'b0;
            hold_left = hold_left - 16'd1;
        end else begin
            vote_a = step_vote(vote_a, a);
            vote_b = step_vote(vote_b, b);
            if (win_left != 16'd0) begin
                win_left = win_left - 16'd1;
            end else begin
                if (vote_a > 0 && vote_b <= 0)      position = POS_CLOSE;
                else if (vote_a <= 0 && vote_b > 0) position = POS_OPEN;
                else if (vote_a <= 0)               position = POS_WORK;
                else                                position = POS_FAULT;
                vote_a     = 8'sd0;
                vote_b     = 8'sd0;
                win_left   = cfg_win;
                ready_seen = 1'b1;
                r.decided  = 1'b1;
            end
        end
        r.pos   = position;
        r.ready = ready_seen;
        return r;
    endfunction

    function automatic void add_cfg(logic [ADDR_BITS-1:0] idx, logic [CFG_BITS-1:0] val);
        plan_row_t row;
        row      = '0;
        row.kind = ROW_CFG;
        row.idx  = idx;
        row.val  = val;
        plan.push_back(row);
    endfunction

    function automatic void add_tick(logic a, logic b, logic [9:0] v, logic known,
                                     pos_t pos, logic rdy, logic dec);
        plan_row_t row;
        row             = '0;
        row.kind        = ROW_TICK;
        row.a           = a;
        row.b           = b;
        row.supply      = v;
        row.known       = known;
        row.res.pos     = pos;
        row.res.ready   = rdy;
        row.res.decided = dec;
        plan.push_back(row);
    endfunction

    function automatic logic [9:0] pick_supply(int low_pct);
        int         roll;
        logic [9:0] v;
        roll = $urandom_range(99, 0);
        if (low_pct > 0 && roll < low_pct && cfg_minv != 10'd0)
            v = 10'($urandom_range(cfg_minv - 1, 0));
        else if (low_pct > 0 && roll < low_pct + 6)
            v = 10'($urandom_range(1023, 0));
        else
            v = 10'($urandom_range(1023, cfg_minv));
        return v;
    endfunction

    task automatic write_reg(input logic [ADDR_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
        while (pending_res.size() != 0) @(negedge aclk);
        cfg_addr    = idx;
        cfg_wr_data = val;
        cfg_wr_en   = 1'b1;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        case (idx)
            REG_MIN_VOLTAGE: cfg_minv = val[9:0];
            REG_HOLDOFF:     cfg_hold = val;
            REG_WINDOW:      cfg_win  = val;
            default: ;
        endcase
    endtask

    task automatic send_tick(input logic a, input logic b, input logic [9:0] v,
                             input logic known, input qual_res_t known_res);
        qual_res_t r;
        while (!calm && $urandom_range(99, 0) < IDLE_PCT) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {4'b0000, v, b, a};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        r = qualify_tick(a, b, v);
        pending_res.push_back(known ? known_res : r);
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    task automatic flag_bad(input qual_res_t want, input qual_res_t got, input bit orphan);
        errors++;
        if (errors <= MAX_REPORTS) begin
            if (orphan)
                $display("unexpected item: pos=%0d ready=%0b decided=%0b",
                         got.pos, got.ready, got.decided);
            else
                $display(
                    "mismatch: want pos=%0d ready=%0b decided=%0b, got pos=%0d ready=%0b decided=%0b",
                    want.pos, want.ready, want.decided, got.pos, got.ready, got.decided);
        end
    endtask

    // result monitor
    initial begin
        qual_res_t got;
        qual_res_t want;
        results_seen = 0;
        errors       = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got = {m_tdata[2:0], m_tdata[3], m_tdata[4]};
                results_seen++;
                if (pending_res.size() == 0) begin
                    flag_bad(got, got, 1'b1);
                end else begin
                    want = pending_res.pop_front();
                    if (got !== want) flag_bad(want, got, 1'b0);
                end
            end
        end
    end

    // result sink with one long hold-off
    initial begin
        bit pressure_done;
        pressure_done = 1'b0;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (!pressure_done && results_seen >= PRESSURE_AT) begin
                pressure_done = 1'b1;
                m_tready = 1'b0;
                repeat (PRESSURE_CYCLES) @(negedge aclk);
            end
            m_tready = calm ? 1'b1 : ($urandom_range(99, 0) >= IDLE_PCT);
        end
    end

    initial begin
        int cycles;
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles >= LIMIT_CYCLES) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        int        n;
        int        low_pct;
        int        pa;
        int        pb;
        logic [15:0] minv_w;
        logic [15:0] hold_w;
        logic [15:0] win_w;
        qual_res_t blank;

        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_wr_en   = 1'b0;
        cfg_addr    = '0;
        cfg_wr_data = '0;
        calm        = 1'b0;
        blank       = '0;

        cfg_minv   = MIN_VOLTAGE_RST;
        cfg_hold   = HOLDOFF_RST;
        cfg_win    = WINDOW_RST;
        vote_a     = 8'sd0;
        vote_b     = 8'sd0;
        win_left   = WINDOW_RST;
        hold_left  = HOLDOFF_RST;
        supply_low = 1'b1;
        position   = POS_UNDEFINED;
        ready_seen = 1'b0;

        add_tick(1'b0, 1'b0, 10'd1023, 1'b1, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b1, 1'b1, 10'd0,    1'b1, POS_UNDEFINED, 1'b0, 1'b0);
        add_cfg(REG_HOLDOFF, 16'd0);
        add_cfg(REG_WINDOW, 16'd0);
        add_cfg(REG_MIN_VOLTAGE, 16'hFFFF);
        add_tick(1'b0, 1'b0, 10'd1022, 1'b1, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b1, 1'b0, 10'd1023, 1'b1, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b1, 1'b0, 10'd1023, 1'b1, POS_CLOSE,     1'b1, 1'b1);
        add_tick(1'b0, 1'b1, 10'd1023, 1'b1, POS_OPEN,      1'b1, 1'b1);
        add_tick(1'b0, 1'b0, 10'd1023, 1'b1, POS_WORK,      1'b1, 1'b1);
        add_tick(1'b1, 1'b1, 10'd1023, 1'b1, POS_FAULT,     1'b1, 1'b1);
        add_tick(1'b1, 1'b1, 10'd0,    1'b1, POS_UNDEFINED, 1'b1, 1'b0);
        add_cfg(REG_SPARE, 16'h0000);
        add_cfg(REG_WINDOW, 16'd2);
        add_cfg(REG_HOLDOFF, 16'd1);
        add_tick(1'b0, 1'b1, 10'd1022, 1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b1, 1'b1, 10'd1023, 1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b1, 1'b0, 10'd1023, 1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b1, 1'b0, 10'd1023, 1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b0, 1'b1, 10'd1023, 1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b1, 1'b1, 10'd1023, 1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b0, 1'b1, 10'd1023, 1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b0, 1'b0, 10'd1023, 1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b1, 1'b1, 10'd1023, 1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_cfg(REG_MIN_VOLTAGE, 16'd0);
        add_tick(1'b1, 1'b0, 10'd0,    1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b0, 1'b1, 10'd0,    1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b1, 1'b1, 10'd512,  1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_cfg(REG_MIN_VOLTAGE, 16'd150);
        add_cfg(REG_HOLDOFF, 16'hFFFF);
        add_cfg(REG_WINDOW, 16'hFFFF);
        add_tick(1'b0, 1'b0, 10'd149,  1'b1, POS_UNDEFINED, 1'b1, 1'b0);
        add_tick(1'b1, 1'b1, 10'd150,  1'b0, POS_UNDEFINED, 1'b0, 1'b0);
        add_tick(1'b0, 1'b0, 10'd1023, 1'b0, POS_UNDEFINED, 1'b0, 1'b0);

        wait (aresetn === 1'b1);
        @(negedge aclk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_CFG)
                write_reg(plan[i].idx, plan[i].val);
            else
                send_tick(plan[i].a, plan[i].b, plan[i].supply, plan[i].known, plan[i].res);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            n       = 130;
            low_pct = 3;
            pa      = $urandom_range(100, 0);
            pb      = $urandom_range(100, 0);
            minv_w  = 16'($urandom_range(1023, 0));
            hold_w  = 16'($urandom_range(10, 0));
            win_w   = 16'($urandom_range(15, 0));
            case (p)
                0: begin
                    minv_w = 16'd150;
                    hold_w = 16'd3;
                    win_w  = 16'd4;
                    low_pct = 4;
                end
                1: begin
                    minv_w = 16'd0;
                    hold_w = 16'd0;
                    win_w  = 16'd0;
                    low_pct = 0;
                end
                2: begin
                    minv_w = 16'd1023;
                    hold_w = 16'd2;
                    win_w  = 16'd1;
                end
                3: begin
                    // long window with strong bias: drive both votes into saturation
                    hold_w  = 16'($urandom_range(20, 0));
                    win_w   = 16'd200;
                    low_pct = 0;
                    pa      = 95;
                    pb      = 5;
                    n       = 260;
                end
                4: begin
                    low_pct = 5;
                end
                6: begin
                    minv_w  = {6'b101010, 10'($urandom_range(1023, 0))};
                    low_pct = 8;
                end
                7: begin
                    minv_w  = 16'($urandom_range(400, 0));
                    hold_w  = 16'hFFFF;
                    low_pct = 2;
                    n       = 60;
                end
                default: ;
            endcase
            write_reg(REG_MIN_VOLTAGE, minv_w);
            write_reg(REG_HOLDOFF, hold_w);
            write_reg(REG_WINDOW, win_w);
            calm = (p == 5);
            repeat (n)
                send_tick($urandom_range(99, 0) < pa, $urandom_range(99, 0) < pb,
                          pick_supply(low_pct), 1'b0, blank);
        end
        calm = 1'b0;

        while (pending_res.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
